### rtl/calorimeter_sqrt_weighted_centroid_defines.svh
// assertion helpers for the centroid block
`ifndef CALORIMETER_SQRT_WEIGHTED_CENTROID_DEFINES_SVH
`define CALORIMETER_SQRT_WEIGHTED_CENTROID_DEFINES_SVH

// same-cycle implication
`define CSWC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cswc_pkg.sv
package cswc_pkg;

  localparam int TOWER_W    = 20;
  localparam int HP_W       = 13;
  localparam int RL_W       = 26;
  localparam int POS_W      = 14;
  localparam int Q_W        = 14;
  localparam int NUM_TWR    = 8;
  localparam int NUM_AXES   = 4;
  localparam int W_FRAC     = 8;
  localparam int SQRT_STEPS = 3;
  localparam int DIV_STEPS  = 4;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam int AX_CX = 0;
  localparam int AX_CY = 1;
  localparam int AX_AX = 2;
  localparam int AX_AY = 3;

  typedef enum logic {
    REG_HALF_PITCH = 1'b0,
    REG_RADIUS_SQ  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } div_ctl_t;

endpackage

### rtl/cswc_sqrt.sv
module cswc_sqrt import cswc_pkg::*; #(
  parameter int ENERGY_BITS = 20,
  localparam int RootW = (ENERGY_BITS + 2 * W_FRAC + 1) / 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_vld,
  input  logic [ENERGY_BITS-1:0] energy [NUM_TWR],
  output logic                   out_vld,
  output logic [RootW-1:0]       root [NUM_TWR]
);

  localparam int RadW  = 2 * RootW;
  localparam int RemW  = RootW + 2;
  localparam int NumSt = (RootW + SQRT_STEPS - 1) / SQRT_STEPS;

  logic [RadW-1:0]  rad_r  [NumSt][NUM_TWR];
  logic [RemW-1:0]  rem_r  [NumSt][NUM_TWR];
  logic [RootW-1:0] root_r [NumSt][NUM_TWR];
  logic [NumSt-1:0] vld_r;

  for (genvar s = 0; s < NumSt; s++) begin : g_st
    logic [RadW-1:0]  src_rad  [NUM_TWR];
    logic [RemW-1:0]  src_rem  [NUM_TWR];
    logic [RootW-1:0] src_root [NUM_TWR];
    logic             src_vld;
    logic [RadW-1:0]  rad_nxt  [NUM_TWR];
    logic [RemW-1:0]  rem_nxt  [NUM_TWR];
    logic [RootW-1:0] root_nxt [NUM_TWR];

    if (s == 0) begin : g_src
      always_comb begin
        for (int l = 0; l < NUM_TWR; l++) begin
          src_rad[l]  = RadW'({energy[l], {(2 * W_FRAC){1'b0}}});
          src_rem[l]  = '0;
          src_root[l] = '0;
        end
        src_vld = in_vld;
      end
    end else begin : g_src
      always_comb begin
        for (int l = 0; l < NUM_TWR; l++) begin
          src_rad[l]  = rad_r[s-1][l];
          src_rem[l]  = rem_r[s-1][l];
          src_root[l] = root_r[s-1][l];
        end
        src_vld = vld_r[s-1];
      end
    end

    always_comb begin
      logic [RadW-1:0]  rad;
      logic [RemW-1:0]  rem;
      logic [RootW-1:0] rt;
      logic [RemW-1:0]  trial;
      for (int l = 0; l < NUM_TWR; l++) begin
        rad = src_rad[l];
        rem = src_rem[l];
        rt  = src_root[l];
        for (int j = 0; j < SQRT_STEPS; j++) begin
          if (s * SQRT_STEPS + j < RootW) begin
            rem   = {rem[RootW-1:0], rad[RadW-1 -: 2]};
            rad   = rad << 2;
            trial = {rt, 2'b01};
            if (rem >= trial) begin
              rem = rem - trial;
              rt  = {rt[RootW-2:0], 1'b1};
            end else begin
              rt  = {rt[RootW-2:0], 1'b0};
            end
          end
        end
        rad_nxt[l]  = rad;
        rem_nxt[l]  = rem;
        root_nxt[l] = rt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[s]  <= rad_nxt;
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
      end
    end
  end

  assign root    = root_r[NumSt-1];
  assign out_vld = vld_r[NumSt-1];

endmodule

### rtl/cswc_div.sv
module cswc_div import cswc_pkg::*; #(
  parameter int ENERGY_BITS = 20,
  localparam int RootW = (ENERGY_BITS + 2 * W_FRAC + 1) / 2,
  localparam int MagW  = RootW + 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_vld,
  input  logic [HP_W-1:0]         hp,
  input  logic [MagW-1:0]         mag [NUM_AXES],
  input  logic [MagW-1:0]         den [NUM_AXES],
  input  div_ctl_t                ctl [NUM_AXES],
  output logic                    out_vld,
  output logic signed [POS_W-1:0] pos [NUM_AXES],
  output div_ctl_t                out_ctl [NUM_AXES]
);

  localparam int DivW  = MagW + 1;
  localparam int ProdW = HP_W + MagW;
  localparam int NumW  = ProdW + 2;
  localparam int NumSt = (Q_W + DIV_STEPS - 1) / DIV_STEPS;

  // product stage
  logic [ProdW-1:0] prod_r  [NUM_AXES];
  logic [MagW-1:0]  den_m_r [NUM_AXES];
  div_ctl_t         ctl_m_r [NUM_AXES];
  logic             vld_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m_r <= 1'b0;
    end else if (adv) begin
      vld_m_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod_r[a]  <= ProdW'(hp) * ProdW'(mag[a]);
        den_m_r[a] <= den[a];
        ctl_m_r[a] <= ctl[a];
      end
    end
  end

  // long division, quotient bits msb first
  logic [DivW-1:0]  rem_r [NumSt][NUM_AXES];
  logic [Q_W-1:0]   low_r [NumSt][NUM_AXES];
  logic [Q_W-1:0]   q_r   [NumSt][NUM_AXES];
  logic [DivW-1:0]  dv_r  [NumSt][NUM_AXES];
  div_ctl_t         ctl_r [NumSt][NUM_AXES];
  logic [NumSt-1:0] vld_r;

  for (genvar s = 0; s < NumSt; s++) begin : g_st
    logic [DivW-1:0] src_rem [NUM_AXES];
    logic [Q_W-1:0]  src_low [NUM_AXES];
    logic [Q_W-1:0]  src_q   [NUM_AXES];
    logic [DivW-1:0] src_dv  [NUM_AXES];
    div_ctl_t        src_ctl [NUM_AXES];
    logic            src_vld;
    logic [DivW-1:0] rem_nxt [NUM_AXES];
    logic [Q_W-1:0]  low_nxt [NUM_AXES];
    logic [Q_W-1:0]  q_nxt   [NUM_AXES];

    if (s == 0) begin : g_src
      always_comb begin
        logic [NumW-1:0] num;
        for (int a = 0; a < NUM_AXES; a++) begin
          num        = {1'b0, prod_r[a], 1'b0} + NumW'(den_m_r[a]);
          src_rem[a] = DivW'(num >> Q_W);
          src_low[a] = num[Q_W-1:0];
          src_q[a]   = '0;
          src_dv[a]  = {den_m_r[a], 1'b0};
          src_ctl[a] = ctl_m_r[a];
        end
        src_vld = vld_m_r;
      end
    end else begin : g_src
      always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
          src_rem[a] = rem_r[s-1][a];
          src_low[a] = low_r[s-1][a];
          src_q[a]   = q_r[s-1][a];
          src_dv[a]  = dv_r[s-1][a];
          src_ctl[a] = ctl_r[s-1][a];
        end
        src_vld = vld_r[s-1];
      end
    end

    always_comb begin
      logic [DivW:0]   rem;
      logic [Q_W-1:0]  low;
      logic [Q_W-1:0]  q;
      for (int a = 0; a < NUM_AXES; a++) begin
        rem = {1'b0, src_rem[a]};
        low = src_low[a];
        q   = src_q[a];
        for (int j = 0; j < DIV_STEPS; j++) begin
          if (s * DIV_STEPS + j < Q_W) begin
            rem = {rem[DivW-1:0], low[Q_W-1]};
            low = low << 1;
            if (rem >= {1'b0, src_dv[a]}) begin
              rem = rem - {1'b0, src_dv[a]};
              q   = {q[Q_W-2:0], 1'b1};
            end else begin
              q   = {q[Q_W-2:0], 1'b0};
            end
          end
        end
        rem_nxt[a] = rem[DivW-1:0];
        low_nxt[a] = low;
        q_nxt[a]   = q;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= rem_nxt;
        low_r[s] <= low_nxt;
        q_r[s]   <= q_nxt;
        dv_r[s]  <= src_dv;
        ctl_r[s] <= src_ctl;
      end
    end
  end

  // sign and invalid-side handling
  logic signed [POS_W-1:0] pos_r     [NUM_AXES];
  div_ctl_t                ctl_o_r   [NUM_AXES];
  logic                    vld_o_r;
  logic signed [POS_W-1:0] pos_nxt   [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (ctl_r[NumSt-1][a].zero) begin
        pos_nxt[a] = '0;
      end else if (ctl_r[NumSt-1][a].neg) begin
        pos_nxt[a] = POS_W'(-q_r[NumSt-1][a]);
      end else begin
        pos_nxt[a] = POS_W'(q_r[NumSt-1][a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o_r <= 1'b0;
    end else if (adv) begin
      vld_o_r <= vld_r[NumSt-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r   <= pos_nxt;
      ctl_o_r <= ctl_r[NumSt-1];
    end
  end

  assign pos     = pos_r;
  assign out_ctl = ctl_o_r;
  assign out_vld = vld_o_r;

endmodule

### rtl/calorimeter_sqrt_weighted_centroid.sv
// Centroid of two 2x2 calorimeters with square-root tower weights.
// Input beat: four tower energies per side (C and A), valid/stall handshake,
// taken at an edge with in_valid high and in_stall low.
// Output beat: x and y of each side (A-side x mirrored), per-side valid flags
// and the accept flag, one output beat for every input beat, in order.
// Registers half_pitch (byte address 0) and radius_limit_sq (byte address 4)
// sit on an APB-style port with pready tied high; write them while idle.
// At the default widths the pipeline holds 6 stages of the square-root
// pipeline (3 result bits a stage), one summing stage, one multiply stage,
// 4 stages of long division (4 quotient bits a stage, 2 in the last), a
// sign stage, a squaring stage and the output register. Throughput is one
// beat per cycle unless stalled. The whole pipeline advances together; when
// out_stall holds a waiting result, every stage and the input side stall
// with it and nothing is lost. Synchronous reset clears all valid bits and
// loads the register defaults 1.75 and 1.5 squared.
`include "calorimeter_sqrt_weighted_centroid_defines.svh"

module calorimeter_sqrt_weighted_centroid import cswc_pkg::*; #(
  parameter int ENERGY_BITS = 20,
  parameter int FRAC_BITS   = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [TOWER_W-1:0]      in_c_tower_1,
  input  logic [TOWER_W-1:0]      in_c_tower_2,
  input  logic [TOWER_W-1:0]      in_c_tower_3,
  input  logic [TOWER_W-1:0]      in_c_tower_4,
  input  logic [TOWER_W-1:0]      in_a_tower_1,
  input  logic [TOWER_W-1:0]      in_a_tower_2,
  input  logic [TOWER_W-1:0]      in_a_tower_3,
  input  logic [TOWER_W-1:0]      in_a_tower_4,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_c_pos_x,
  output logic signed [POS_W-1:0] out_c_pos_y,
  output logic signed [POS_W-1:0] out_a_pos_x,
  output logic signed [POS_W-1:0] out_a_pos_y,
  output logic                    out_c_valid,
  output logic                    out_a_valid,
  output logic                    out_accept,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  localparam int RootW = (ENERGY_BITS + 2 * W_FRAC + 1) / 2;
  localparam int MagW  = RootW + 2;
  localparam int SqW   = 2 * POS_W - 1;
  localparam logic [HP_W-1:0] HpRst = HP_W'((64'd7 << FRAC_BITS) / 4);
  localparam logic [RL_W-1:0] RlRst = RL_W'((64'd9 << (2 * FRAC_BITS)) / 4);

  logic adv;

  // configuration
  logic [HP_W-1:0] hp_r, hp_nxt;
  logic [RL_W-1:0] rl_r, rl_nxt;
  logic            cfg_wr;
  reg_idx_t        reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    hp_nxt = hp_r;
    rl_nxt = rl_r;
    prdata = '0;
    unique case (reg_idx)
      REG_HALF_PITCH: begin
        prdata = APB_DW'(hp_r);
        if (cfg_wr) hp_nxt = pwdata[HP_W-1:0];
      end
      REG_RADIUS_SQ: begin
        prdata = APB_DW'(rl_r);
        if (cfg_wr) rl_nxt = pwdata[RL_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r <= HpRst;
      rl_r <= RlRst;
    end else begin
      hp_r <= hp_nxt;
      rl_r <= rl_nxt;
    end
  end

  // square roots of all eight towers
  logic [ENERGY_BITS-1:0] energy [NUM_TWR];
  logic [RootW-1:0]       root   [NUM_TWR];
  logic                   sq_vld;

  assign energy[0] = ENERGY_BITS'(in_c_tower_1);
  assign energy[1] = ENERGY_BITS'(in_c_tower_2);
  assign energy[2] = ENERGY_BITS'(in_c_tower_3);
  assign energy[3] = ENERGY_BITS'(in_c_tower_4);
  assign energy[4] = ENERGY_BITS'(in_a_tower_1);
  assign energy[5] = ENERGY_BITS'(in_a_tower_2);
  assign energy[6] = ENERGY_BITS'(in_a_tower_3);
  assign energy[7] = ENERGY_BITS'(in_a_tower_4);

  cswc_sqrt #(.ENERGY_BITS(ENERGY_BITS)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .energy  (energy),
    .out_vld (sq_vld),
    .root    (root)
  );

  // weight sums and differences
  logic [MagW-1:0] mag_r [NUM_AXES], mag_nxt [NUM_AXES];
  logic [MagW-1:0] den_r [NUM_AXES], den_nxt [NUM_AXES];
  div_ctl_t        ctl_r [NUM_AXES], ctl_nxt [NUM_AXES];
  logic            sum_vld_r;

  always_comb begin
    logic [MagW-1:0]   den;
    logic signed [MagW:0] dx, dy;
    for (int k = 0; k < 2; k++) begin
      den = MagW'(root[4*k]) + MagW'(root[4*k+1]) + MagW'(root[4*k+2])
          + MagW'(root[4*k+3]);
      dx  = $signed((MagW + 1)'(root[4*k+1]) + (MagW + 1)'(root[4*k+3]))
          - $signed((MagW + 1)'(root[4*k]) + (MagW + 1)'(root[4*k+2]));
      dy  = $signed((MagW + 1)'(root[4*k+2]) + (MagW + 1)'(root[4*k+3]))
          - $signed((MagW + 1)'(root[4*k]) + (MagW + 1)'(root[4*k+1]));
      mag_nxt[2*k]        = dx[MagW] ? MagW'(-dx) : MagW'(dx);
      mag_nxt[2*k+1]      = dy[MagW] ? MagW'(-dy) : MagW'(dy);
      den_nxt[2*k]        = den;
      den_nxt[2*k+1]      = den;
      ctl_nxt[2*k].zero   = (den == '0);
      ctl_nxt[2*k+1].zero = (den == '0);
      ctl_nxt[2*k+1].neg  = dy[MagW];
      // a-side x is mirrored
      ctl_nxt[2*k].neg    = (k == 0) ? dx[MagW] : !dx[MagW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else if (adv) begin
      sum_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r <= mag_nxt;
      den_r <= den_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  // scaled ratio
  logic signed [POS_W-1:0] pos     [NUM_AXES];
  div_ctl_t                pos_ctl [NUM_AXES];
  logic                    div_vld;

  cswc_div #(.ENERGY_BITS(ENERGY_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (sum_vld_r),
    .hp      (hp_r),
    .mag     (mag_r),
    .den     (den_r),
    .ctl     (ctl_r),
    .out_vld (div_vld),
    .pos     (pos),
    .out_ctl (pos_ctl)
  );

  // squares
  logic [SqW-1:0]          sq_r     [NUM_AXES], sq_nxt [NUM_AXES];
  logic signed [POS_W-1:0] pos_sq_r [NUM_AXES];
  logic                    cv_sq_r, av_sq_r, vld_sq_r;

  always_comb begin
    logic signed [2*POS_W-1:0] p;
    for (int a = 0; a < NUM_AXES; a++) begin
      p         = pos[a] * pos[a];
      sq_nxt[a] = p[SqW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_sq_r <= 1'b0;
    end else if (adv) begin
      vld_sq_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r     <= sq_nxt;
      pos_sq_r <= pos;
      cv_sq_r  <= !pos_ctl[AX_CX].zero;
      av_sq_r  <= !pos_ctl[AX_AX].zero;
    end
  end

  // radius cut and output register
  logic out_valid_r, acc_nxt, acc_r, cv_r, av_r;
  logic signed [POS_W-1:0] cx_r, cy_r, ax_r, ay_r;
  logic [2*POS_W-1:0] rc, ra;

  always_comb begin
    rc      = (2*POS_W)'(sq_r[AX_CX]) + (2*POS_W)'(sq_r[AX_CY]);
    ra      = (2*POS_W)'(sq_r[AX_AX]) + (2*POS_W)'(sq_r[AX_AY]);
    acc_nxt = cv_sq_r && av_sq_r && (rc <= (2*POS_W)'(rl_r))
              && (ra <= (2*POS_W)'(rl_r));
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_sq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r  <= pos_sq_r[AX_CX];
      cy_r  <= pos_sq_r[AX_CY];
      ax_r  <= pos_sq_r[AX_AX];
      ay_r  <= pos_sq_r[AX_AY];
      cv_r  <= cv_sq_r;
      av_r  <= av_sq_r;
      acc_r <= acc_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_c_pos_x = cx_r;
  assign out_c_pos_y = cy_r;
  assign out_a_pos_x = ax_r;
  assign out_a_pos_y = ay_r;
  assign out_c_valid = cv_r;
  assign out_a_valid = av_r;
  assign out_accept  = acc_r;

  `CSWC_ASSERT_IMPL(a_accept_needs_sides, out_valid && out_accept,
    out_c_valid && out_a_valid, "accept without both sides valid")
  `CSWC_ASSERT_IMPL(a_c_invalid_zero, out_valid && !out_c_valid,
    out_c_pos_x == '0 && out_c_pos_y == '0, "invalid c side has nonzero position")
  `CSWC_ASSERT_IMPL(a_a_invalid_zero, out_valid && !out_a_valid,
    out_a_pos_x == '0 && out_a_pos_y == '0, "invalid a side has nonzero position")
  `CSWC_ASSERT_NEXT(a_hp_write,
    rst_n && psel && penable && pwrite && pready && reg_idx == REG_HALF_PITCH,
    hp_r == $past(pwdata[HP_W-1:0]), "half pitch write lost")

endmodule
